// ===== rtl/core/spim_pkg.sv =====
`default_nettype none

package spim_pkg;

	// Bits shifted in one byte transfer.
	localparam int unsigned BITS_PER_WORD = 8;
	localparam int unsigned CNT_W         = 16;
	localparam int unsigned BITS_W        = 4;

	// Request codes carried on the input channel's tuser.
	localparam logic [2:0] REQ_TICK     = 3'd0;
	localparam logic [2:0] REQ_SEND     = 3'd1;
	localparam logic [2:0] REQ_RECV     = 3'd2;
	localparam logic [2:0] REQ_SELECT   = 3'd3;
	localparam logic [2:0] REQ_DESELECT = 3'd4;

	// Configuration register indexes.
	localparam logic CFG_SPI_MODE    = 1'b0;
	localparam logic CFG_HALF_PERIOD = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [1:0]       MODE_RESET = 2'd1;
	localparam logic [CNT_W-1:0] HALF_RESET = 16'd1;

	typedef enum logic [2:0] {
		KIND_IDLE = 3'b001,
		KIND_SEND = 3'b010,
		KIND_RECV = 3'b100
	} spim_kind_t;

	typedef struct packed {
		spim_kind_t         kind;
		logic [7:0]         shift;
		logic [BITS_W-1:0]  bits_left;
		logic [CNT_W-1:0]   tick_count;
		logic               second_half;
		logic               clock_level;
		logic               data_level;
		logic               select_level;
	} spim_state_t;

	typedef struct packed {
		logic       sclk;
		logic       mosi;
		logic       cs_n;
		logic       busy;
		logic [7:0] rx_byte;
		logic       rx_done;
	} spim_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/spi_master_four_mode_byte_engine.sv =====
`default_nettype none

// SPI master byte engine for clock modes 0 to 3, half duplex, driven by ticks.
// Every transfer on the s_axis channel is one tick of the bit timer. Its tuser
// carries the request (tick only, send, receive, select, deselect), its tdata
// the byte to send and the sampled level of the slave data line. Each accepted
// tick yields exactly one transfer on the m_axis channel with the line levels
// after that tick (sclk, mosi, cs_n), the busy flag and, on the finishing tick
// of a byte, rx_done in tuser with the received byte in tdata.
// The result of a tick is registered and presented in the cycle after it
// is accepted. Throughput is one tick per cycle while the receiver keeps up;
// the only loop is the engine state register fed by one pass of the step logic.
// If the receiver stalls, the result register holds its transfer and s_axis
// tready drops, so ticks stop until the result is taken; no tick is lost.
// The cfg channel writes spi_mode (index 0) and half_period_ticks (index 1);
// it is always ready and is meant to be used while the engine is idle.
// After reset: mode 1, one tick per half bit, chip select high, engine idle,
// and no result pending.
module spi_master_four_mode_byte_engine (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // [7:0] tx_byte, [8] miso_level, rest zero
	input  wire logic [2:0]  s_axis_tuser,  // [2:0] req_type
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // [0] sclk, [1] mosi, [2] cs_n, [3] busy_res,
	                                        // [11:4] rx_byte, rest zero
	output logic             m_axis_tuser,  // [0] rx_done
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data
);

	logic [1:0]                 spi_mode_q;
	logic [spim_pkg::CNT_W-1:0] half_period_q;
	spim_pkg::spim_state_t      state_q;
	spim_pkg::spim_state_t      state_nxt;
	spim_pkg::spim_result_t     res_nxt;
	spim_pkg::spim_result_t     res_q;
	logic                       out_valid_q;
	logic                       in_xfer;

	// The result register frees up when it is empty or being drained.
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spi_mode_q    <= spim_pkg::MODE_RESET;
			half_period_q <= spim_pkg::HALF_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				spim_pkg::CFG_SPI_MODE:    spi_mode_q    <= cfg_data[1:0];
				spim_pkg::CFG_HALF_PERIOD: half_period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	spim_step u_step (
		.cur         (state_q),
		.req_type    (s_axis_tuser),
		.tx_byte     (s_axis_tdata[7:0]),
		.miso_level  (s_axis_tdata[8]),
		.spi_mode    (spi_mode_q),
		.half_period (half_period_q),
		.nxt         (state_nxt),
		.res         (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.kind         <= spim_pkg::KIND_IDLE;
			state_q.shift        <= 8'd0;
			state_q.bits_left    <= '0;
			state_q.tick_count   <= '0;
			state_q.second_half  <= 1'b0;
			state_q.clock_level  <= 1'b0;
			state_q.data_level   <= 1'b0;
			state_q.select_level <= 1'b1;
			out_valid_q          <= 1'b0;
		end else begin
			if (in_xfer) begin
				state_q <= state_nxt;
			end
			if (in_xfer) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload needs no reset; it is qualified by out_valid_q.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			res_q <= res_nxt;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, res_q.rx_byte, res_q.busy, res_q.cs_n, res_q.mosi, res_q.sclk};
	assign m_axis_tuser  = res_q.rx_done;

	// A finishing tick already reports the engine as free.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(res_q.rx_done && res_q.busy))
		else $error("rx_done reported together with busy");

	// The received byte is only shown on a finishing tick.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !res_q.rx_done) |-> (res_q.rx_byte == 8'd0))
		else $error("rx_byte nonzero outside a finishing tick");

	// The bit counter is nonzero exactly while a byte is in progress.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.kind == spim_pkg::KIND_IDLE) == (state_q.bits_left == '0))
		else $error("bit counter out of step with transfer kind");

	// An idle engine keeps its bit timer cleared.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.kind == spim_pkg::KIND_IDLE) |->
			(state_q.tick_count == '0 && !state_q.second_half))
		else $error("bit timer not cleared while idle");

	// A tick that leaves the engine idle drives the clock to its idle level.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && state_nxt.kind == spim_pkg::KIND_IDLE)
			|=> (res_q.sclk == $past(spi_mode_q[1])))
		else $error("idle clock level does not follow polarity");

endmodule

`default_nettype wire

// ===== rtl/core/spim_step.sv =====
`default_nettype none

// Next-state and result logic for one tick of the bit timer.
module spim_step (
	input  spim_pkg::spim_state_t           cur,
	input  logic [2:0]                      req_type,
	input  logic [7:0]                      tx_byte,
	input  logic                            miso_level,
	input  logic [1:0]                      spi_mode,
	input  logic [spim_pkg::CNT_W-1:0]      half_period,
	output spim_pkg::spim_state_t           nxt,
	output spim_pkg::spim_result_t          res
);

	logic                           cpol;
	logic                           cpha;
	logic [spim_pkg::CNT_W-1:0]     cnt_inc;
	logic [7:0]                     shift_tmp;
	logic [spim_pkg::BITS_W-1:0]    bits_dec;
	logic [7:0]                     rxb;
	logic                           done;

	assign cpol    = spi_mode[1];
	assign cpha    = spi_mode[0];
	assign cnt_inc = cur.tick_count + spim_pkg::CNT_W'(1);

	always_comb begin
		nxt       = cur;
		rxb       = 8'd0;
		done      = 1'b0;
		shift_tmp = cur.shift;
		bits_dec  = cur.bits_left - spim_pkg::BITS_W'(1);
		if (cur.kind == spim_pkg::KIND_IDLE) begin
			nxt.clock_level = cpol;
			if (req_type == spim_pkg::REQ_SEND || req_type == spim_pkg::REQ_RECV) begin
				if (req_type == spim_pkg::REQ_SEND) begin
					nxt.shift      = tx_byte;
					nxt.data_level = tx_byte[7];
					nxt.kind       = spim_pkg::KIND_SEND;
				end else begin
					nxt.shift = 8'd0;
					nxt.kind  = spim_pkg::KIND_RECV;
				end
				nxt.bits_left   = spim_pkg::BITS_W'(spim_pkg::BITS_PER_WORD);
				nxt.tick_count  = '0;
				nxt.second_half = 1'b0;
				nxt.clock_level = cpha ? ~cpol : cpol;
			end else if (req_type == spim_pkg::REQ_SELECT) begin
				nxt.select_level = 1'b0;
			end else if (req_type == spim_pkg::REQ_DESELECT) begin
				nxt.select_level = 1'b1;
			end
		end else begin
			nxt.tick_count = cnt_inc;
			if (cnt_inc >= half_period) begin
				nxt.tick_count = '0;
				if (!cur.second_half) begin
					nxt.second_half = 1'b1;
					if (cpha) begin
						nxt.clock_level = cpol;
						if (cur.kind == spim_pkg::KIND_RECV) begin
							nxt.shift = {cur.shift[6:0], miso_level};
						end
					end else begin
						nxt.clock_level = ~cpol;
					end
				end else begin
					nxt.second_half = 1'b0;
					if (!cpha && cur.kind == spim_pkg::KIND_RECV) begin
						shift_tmp = {cur.shift[6:0], miso_level};
					end
					nxt.clock_level = cpol;
					if (cur.kind == spim_pkg::KIND_SEND) begin
						shift_tmp = {shift_tmp[6:0], 1'b0};
					end
					nxt.shift     = shift_tmp;
					nxt.bits_left = bits_dec;
					if (bits_dec == '0) begin
						rxb      = (cur.kind == spim_pkg::KIND_RECV) ? shift_tmp : 8'd0;
						done     = 1'b1;
						nxt.kind = spim_pkg::KIND_IDLE;
					end else begin
						if (cur.kind == spim_pkg::KIND_SEND) begin
							nxt.data_level = shift_tmp[7];
						end
						if (cpha) begin
							nxt.clock_level = ~cpol;
						end
					end
				end
			end
		end
	end

	always_comb begin
		res.sclk    = nxt.clock_level;
		res.mosi    = nxt.data_level;
		res.cs_n    = nxt.select_level;
		res.busy    = (nxt.kind != spim_pkg::KIND_IDLE);
		res.rx_byte = rxb;
		res.rx_done = done;
	end

endmodule

`default_nettype wire

// ===== test/tb_spi_master_four_mode_byte_engine.sv =====
module tb_spi_master_four_mode_byte_engine;
	import spim_pkg::*;

	// The run is stopped as failed after this many clock cycles. The slowest
	// correct run is far below it, even with both sides stalling most cycles.
	localparam int unsigned CYCLE_LIMIT  = 2_000_000;
	localparam int unsigned RANDOM_TICKS = 2000;
	localparam int unsigned SEGMENTS     = 8;
	localparam int unsigned MAX_PRINTED  = 40;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic [2:0]  s_axis_tuser = REQ_TICK;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = CFG_SPI_MODE;
	logic [15:0] cfg_data = '0;

	spi_master_four_mode_byte_engine dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Configuration as the engine should currently see it.
	logic [1:0]       cfg_mode = MODE_RESET;
	logic [CNT_W-1:0] cfg_half = HALF_RESET;

	// Our own copy of the engine state, advanced once per accepted tick.
	spim_kind_t        eng_kind   = KIND_IDLE;
	logic [7:0]        eng_shift  = '0;
	logic [BITS_W-1:0] eng_bits   = '0;
	logic [CNT_W-1:0]  eng_ticks  = '0;
	logic              eng_second = 1'b0;
	logic              eng_sclk   = 1'b0;
	logic              eng_mosi   = 1'b0;
	logic              eng_cs_n   = 1'b1;

	// Line levels expected for each accepted tick, oldest first.
	spim_result_t pending_levels_q[$];

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_request   = 0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count    = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	// Watchdog: a run that has not ended by the limit has hung somewhere.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL spi_master_four_mode_byte_engine");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		if (mismatch_count < MAX_PRINTED)
			$display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what,
				got, want);
		mismatch_count++;
	endtask

	// Advance the engine by one tick and return the line levels after it.
	// CPHA 0 sets data with the clock idle, makes the leading edge at mid
	// bit and samples just before the trailing edge. CPHA 1 opens the bit with
	// the leading edge and samples on the trailing edge at mid bit.
	function automatic spim_result_t advance_engine(input logic [2:0] req,
			input logic [7:0] tx, input logic miso);
		spim_result_t lv;
		logic cpol;
		logic cpha;
		logic [7:0] got_byte;
		logic done;
		cpol = cfg_mode[1];
		cpha = cfg_mode[0];
		got_byte = '0;
		done = 1'b0;
		if (eng_kind == KIND_IDLE) begin
			// While idle the clock tracks the current polarity every tick.
			eng_sclk = cpol;
			if (req == REQ_SEND || req == REQ_RECV) begin
				if (req == REQ_SEND) begin
					eng_shift = tx;
					eng_mosi = tx[7];
					eng_kind = KIND_SEND;
				end else begin
					// A receive leaves the data line where it was.
					eng_shift = '0;
					eng_kind = KIND_RECV;
				end
				eng_bits = BITS_W'(BITS_PER_WORD);
				eng_ticks = '0;
				eng_second = 1'b0;
				eng_sclk = cpha ? ~cpol : cpol;
			end else if (req == REQ_SELECT) begin
				eng_cs_n = 1'b0;
			end else if (req == REQ_DESELECT) begin
				eng_cs_n = 1'b1;
			end
			// Codes above deselect are plain ticks.
		end else begin
			// Busy: every request is ignored and only the bit timer moves. A zero
			// half period compares true on every tick, so it acts like one.
			eng_ticks = eng_ticks + CNT_W'(1);
			if (eng_ticks >= cfg_half) begin
				eng_ticks = '0;
				if (!eng_second) begin
					eng_second = 1'b1;
					if (cpha) begin
						eng_sclk = cpol;
						if (eng_kind == KIND_RECV)
							eng_shift = {eng_shift[6:0], miso};
					end else begin
						eng_sclk = ~cpol;
					end
				end else begin
					eng_second = 1'b0;
					if (!cpha && eng_kind == KIND_RECV)
						eng_shift = {eng_shift[6:0], miso};
					eng_sclk = cpol;
					if (eng_kind == KIND_SEND)
						eng_shift = {eng_shift[6:0], 1'b0};
					eng_bits = eng_bits - BITS_W'(1);
					if (eng_bits == '0) begin
						// The byte ends here; busy is already low on this tick and
						// the last bit sent stays on the data line.
						if (eng_kind == KIND_RECV)
							got_byte = eng_shift;
						done = 1'b1;
						eng_kind = KIND_IDLE;
					end else begin
						if (eng_kind == KIND_SEND)
							eng_mosi = eng_shift[7];
						if (cpha)
							eng_sclk = ~cpol;
					end
				end
			end
		end
		lv.sclk = eng_sclk;
		lv.mosi = eng_mosi;
		lv.cs_n = eng_cs_n;
		lv.busy = (eng_kind != KIND_IDLE);
		lv.rx_byte = got_byte;
		lv.rx_done = done;
		return lv;
	endfunction

	// Receiving side: compares each result transfer with the oldest
	// expectation and then decides whether to stall on the next cycle. A long
	// hold-off, when requested, is counted down here cycle by cycle.
	int unsigned hold_left = 0;

	always @(posedge clk) begin
		spim_result_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_levels_q.size() == 0) begin
				report_mismatch("unexpected result", m_axis_tdata, 16'd0);
			end else begin
				want = pending_levels_q.pop_front();
				if (m_axis_tdata[0] !== want.sclk)
					report_mismatch("sclk", 16'(m_axis_tdata[0]), 16'(want.sclk));
				if (m_axis_tdata[1] !== want.mosi)
					report_mismatch("mosi", 16'(m_axis_tdata[1]), 16'(want.mosi));
				if (m_axis_tdata[2] !== want.cs_n)
					report_mismatch("cs_n", 16'(m_axis_tdata[2]), 16'(want.cs_n));
				if (m_axis_tdata[3] !== want.busy)
					report_mismatch("busy", 16'(m_axis_tdata[3]), 16'(want.busy));
				if (m_axis_tdata[11:4] !== want.rx_byte)
					report_mismatch("rx_byte", 16'(m_axis_tdata[11:4]),
						16'(want.rx_byte));
				if (m_axis_tuser !== want.rx_done)
					report_mismatch("rx_done", 16'(m_axis_tuser), 16'(want.rx_done));
			end
		end
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Offers one tick and waits for its transfer. The valid stays high into the
	// next call unless the sender decides to go idle for a while.
	task automatic push_tick(input logic [2:0] req, input logic [7:0] tx, input logic miso);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= req;
		s_axis_tdata <= {7'd0, miso, tx};
		do @(posedge clk); while (!s_axis_tready);
		pending_levels_q.push_back(advance_engine(req, tx, miso));
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	// Stops offering ticks and waits until every expected result has come.
	task automatic drain();
		if (s_axis_tvalid)
			s_axis_tvalid <= 1'b0;
		while (pending_levels_q.size() != 0)
			@(posedge clk);
	endtask

	// Writes one register, then leaves the channel idle so that a
	// following write starts on a later edge.
	task automatic write_reg(input logic idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_SPI_MODE)
			cfg_mode = value[1:0];
		else
			cfg_half = value;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [15:0] mode_word, input logic [15:0] half);
		drain();
		write_reg(CFG_SPI_MODE, mode_word);
		write_reg(CFG_HALF_PERIOD, half);
	endtask

	task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	// Plain ticks with a random slave data level.
	task automatic run_ticks(input int unsigned count);
		repeat (count)
			push_tick(REQ_TICK, 8'($urandom), 1'($urandom));
	endtask

	// Ticks until the byte in progress has finished. Now and then a request
	// is mixed in, which the busy engine must ignore. A negative level asks
	// for a random slave data line, otherwise the line is held at that level.
	task automatic finish_byte(input int miso_fix);
		logic [2:0] req;
		logic miso;
		while (eng_kind != KIND_IDLE) begin
			req = ($urandom_range(7) == 0) ? 3'($urandom_range(7, 1)) : REQ_TICK;
			miso = (miso_fix < 0) ? 1'($urandom) : miso_fix[0];
			push_tick(req, 8'($urandom), miso);
		end
	endtask

	// Idle engine: the clock follows the polarity, select and deselect move
	// chip select, and the unused codes act as plain ticks.
	task automatic test_idle_requests();
		set_idling(0, 0);
		configure(16'd3, 16'd1);
		push_tick(REQ_TICK, 8'hFF, 1'b1);
		push_tick(3'd5, 8'h00, 1'b0);
		push_tick(REQ_SELECT, 8'h00, 1'b0);
		push_tick(3'd6, 8'hFF, 1'b1);
		push_tick(3'd7, 8'h55, 1'b0);
		push_tick(REQ_DESELECT, 8'hAA, 1'b1);
		configure(16'd2, 16'd1);
		push_tick(REQ_TICK, 8'h00, 1'b0);
		push_tick(REQ_SELECT, 8'h00, 1'b0);
		configure(16'd0, 16'd1);
		push_tick(REQ_TICK, 8'h00, 1'b0);
	endtask

	// One send and one receive in every mode, with the extreme bytes and a
	// zero half period. A new request follows right on the finishing tick.
	task automatic test_byte_each_mode();
		set_idling(13, 13);
		configure(16'd0, 16'd0);
		push_tick(REQ_SEND, 8'hFF, 1'b0);
		finish_byte(0);
		push_tick(REQ_RECV, 8'h00, 1'b1);
		finish_byte(1);
		configure(16'd1, 16'd1);
		push_tick(REQ_RECV, 8'hFF, 1'b0);
		finish_byte(0);
		push_tick(REQ_SEND, 8'h01, 1'b0);
		finish_byte(-1);
		run_ticks(2);
		configure(16'd2, 16'd2);
		push_tick(REQ_SEND, 8'h80, 1'b1);
		finish_byte(-1);
		push_tick(REQ_RECV, 8'h00, 1'b0);
		finish_byte(-1);
		configure(16'd3, 16'd3);
		push_tick(REQ_RECV, 8'h00, 1'b1);
		finish_byte(-1);
		push_tick(REQ_SEND, 8'h7F, 1'b0);
		finish_byte(-1);
	endtask

	// The mode changes while a byte is in flight; the engine picks it up at
	// the next edge it makes.
	task automatic test_mode_mid_byte();
		set_idling(0, 0);
		configure(16'd0, 16'd2);
		push_tick(REQ_SEND, 8'hC3, 1'b0);
		run_ticks(9);
		drain();
		write_reg(CFG_SPI_MODE, 16'd3);
		finish_byte(-1);
		drain();
		write_reg(CFG_SPI_MODE, 16'd1);
		push_tick(REQ_RECV, 8'h00, 1'b0);
		run_ticks(5);
		drain();
		write_reg(CFG_SPI_MODE, 16'd2);
		finish_byte(-1);
	endtask

	// Largest half period: no edge can come within a few hundred ticks. The
	// period is then cut to zero so that the byte completes quickly.
	task automatic test_long_half_period();
		set_idling(0, 0);
		configure(16'd1, 16'hFFFF);
		push_tick(REQ_RECV, 8'h00, 1'b1);
		run_ticks(300);
		drain();
		write_reg(CFG_HALF_PERIOD, 16'd0);
		finish_byte(-1);
	endtask

	// The receiver holds off for a long stretch while ticks keep coming, so
	// the block fills up and must stall its input without losing a tick.
	task automatic test_receiver_hold_off();
		set_idling(0, 0);
		configure(16'd2, 16'd1);
		hold_request = 300;
		push_tick(REQ_SEND, 8'($urandom), 1'($urandom));
		run_ticks(80);
		drain();
	endtask

	// Random traffic in segments. Each segment starts from an idle engine with
	// a fresh mode and half period and runs under one of the idling patterns.
	// An idle engine mostly gets byte requests, a busy one mostly plain ticks.
	task automatic test_random_traffic();
		logic [2:0] req;
		logic [15:0] half;
		int unsigned pick;
		for (int unsigned seg = 0; seg < SEGMENTS; seg++) begin
			case (seg % 4)
				0: begin
					set_idling(0, 0);
				end
				1: begin
					set_idling(69, 0);
				end
				2: begin
					set_idling(0, 69);
				end
				default: begin
					set_idling(13, 13);
				end
			endcase
			finish_byte(-1);
			half = ($urandom_range(9) == 0) ? 16'd9 : 16'($urandom_range(4));
			// Only the low two bits of the mode word matter.
			configure({14'($urandom), 2'($urandom_range(3))}, half);
			repeat (RANDOM_TICKS / SEGMENTS) begin
				pick = $urandom_range(99);
				if (eng_kind != KIND_IDLE)
					req = (pick < 92) ? REQ_TICK : 3'($urandom_range(7, 1));
				else if (pick < 35)
					req = REQ_SEND;
				else if (pick < 70)
					req = REQ_RECV;
				else if (pick < 80)
					req = REQ_SELECT;
				else if (pick < 90)
					req = REQ_DESELECT;
				else
					req = 3'($urandom_range(7));
				push_tick(req, 8'($urandom), 1'($urandom));
			end
		end
		finish_byte(-1);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_requests();
		test_byte_each_mode();
		test_mode_mid_byte();
		test_long_half_period();
		test_receiver_hold_off();
		test_random_traffic();
		drain();
		// The result of a tick is registered; waiting on after the drain shows any
		// result transfer that should not be there.
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && pending_levels_q.size() == 0)
			$display("PASS spi_master_four_mode_byte_engine");
		else
			$display("FAIL spi_master_four_mode_byte_engine");
		$finish;
	end

endmodule
